>>> hw/rtl/slew_pkg.sv
// ----------------------------------------------------------------------------
// slew_pkg
// Shared widths, register indexes and types of the asymmetric slew smoother.
// ----------------------------------------------------------------------------
package slew_pkg;

    localparam int DATA_W   = 32;
    localparam int CHAN_W   = 3;
    localparam int COEF_W   = 16;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_CHANNELS_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_COEF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_COEF     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

    localparam logic [CNT_W-1:0] CHAN_COUNT_RST = 4'd2;

    // read view of one channel slot
    typedef struct packed {
        logic                     loaded;
        logic signed [DATA_W-1:0] value;
    } t_chan_state;

    // write into the channel store
    typedef struct packed {
        logic                     en;
        logic [CHAN_W-1:0]        idx;
        logic signed [DATA_W-1:0] value;
    } t_store_wr;

endpackage

>>> hw/rtl/slew_step.sv
// ----------------------------------------------------------------------------
// slew_step
// One-pole step toward the target with rise/fall coefficient selection.
// ----------------------------------------------------------------------------
module slew_step (
    input  logic signed [slew_pkg::DATA_W-1:0] i_value,
    input  logic signed [slew_pkg::DATA_W-1:0] i_target,
    input  logic        [slew_pkg::COEF_W-1:0] i_rise_coef,
    input  logic        [slew_pkg::COEF_W-1:0] i_fall_coef,
    output logic signed [slew_pkg::DATA_W-1:0] o_result
);

    localparam int DW = slew_pkg::DATA_W;
    localparam int CW = slew_pkg::COEF_W;

    logic signed [DW:0]      diff;
    logic signed [CW:0]      alpha;
    logic signed [DW+CW+1:0] prod;

    assign diff  = {i_value[DW-1], i_value} - {i_target[DW-1], i_target};
    // rise when target above value; equal values give a zero step either way
    assign alpha = (i_target > i_value) ? $signed({1'b0, i_rise_coef})
                                        : $signed({1'b0, i_fall_coef});
    assign prod  = alpha * diff;

    // floor shift by 16, the result always lands between target and value
    assign o_result = i_target + $signed(prod[DW+CW-1:CW]);

endmodule

>>> hw/rtl/slew_store.sv
// ----------------------------------------------------------------------------
// slew_store
// Per-channel smoothed values and loaded marks.
// ----------------------------------------------------------------------------
module slew_store #(
    parameter int NUM_SLOTS = slew_pkg::MAX_CHANNELS_DEF,
    parameter int IDX_W     = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clr,
    input  logic [slew_pkg::CHAN_W-1:0]   i_rd_idx,
    output slew_pkg::t_chan_state         o_rd,
    input  slew_pkg::t_store_wr           i_wr
);

    logic signed [slew_pkg::DATA_W-1:0] r_value [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]               r_loaded;
    logic [NUM_SLOTS-1:0]               n_loaded;
    logic [IDX_W-1:0]                   rd_idx;
    logic [IDX_W-1:0]                   wr_idx;

    assign rd_idx = i_rd_idx[IDX_W-1:0];
    assign wr_idx = i_wr.idx[IDX_W-1:0];

    assign o_rd.loaded = r_loaded[rd_idx];
    assign o_rd.value  = r_value[rd_idx];

    always_comb begin
        n_loaded = r_loaded;
        if (i_clr) begin
            n_loaded = '0;
        end else if (i_wr.en) begin
            n_loaded[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= '0;
        end else begin
            r_loaded <= n_loaded;
        end
    end

    // values have no reset, a slot is read only once it is loaded
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_value[wr_idx] <= i_wr.value;
        end
    end

    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr |=> (r_loaded == '0))
        else $error("loaded marks survive a clear");

    a_wr_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && !i_clr) |=> r_loaded[$past(wr_idx)])
        else $error("written slot not marked loaded");

endmodule

>>> hw/rtl/asymmetric_slew_smoother.sv
// ----------------------------------------------------------------------------
// asymmetric_slew_smoother
// Per-channel asymmetric one-pole slew limiter on signed Q16.16 samples.
// ----------------------------------------------------------------------------
// path: the accepting edge loads the input register, and the result is registered
//   when the item moves on (step logic into the output register)
// throughput: one item per cycle unless the output stalls; the store of a channel
//   in use is updated as the result is registered so its next item sees it
// reset: config returns to slew off, coefficients zero, two channels in use;
//   all channel loaded marks clear, stored values are left as they are
module asymmetric_slew_smoother #(
    parameter int MAX_CHANNELS = slew_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic        [slew_pkg::CHAN_W-1:0]    i_chan_index,
    input  logic signed [slew_pkg::DATA_W-1:0]    i_target_value,
    // result items
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic        [slew_pkg::CHAN_W-1:0]    o_out_chan,
    output logic signed [slew_pkg::DATA_W-1:0]    o_out_value,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [slew_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [slew_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // only channel codes that fit the index field can ever be used
    localparam int NUM_SLOTS = (MAX_CHANNELS < (1 << slew_pkg::CHAN_W)) ?
                               MAX_CHANNELS : (1 << slew_pkg::CHAN_W);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [slew_pkg::CNT_W-1:0] SLOT_LIMIT = slew_pkg::CNT_W'(NUM_SLOTS);

    // configuration
    logic                           r_slew_en;
    logic [slew_pkg::COEF_W-1:0]    r_rise_coef;
    logic [slew_pkg::COEF_W-1:0]    r_fall_coef;
    logic [slew_pkg::CNT_W-1:0]     r_chan_count;
    logic                           cfg_wr;
    logic                           clr_loaded;

    // pipeline
    logic                           r_in_valid;
    logic [slew_pkg::CHAN_W-1:0]    r_in_chan;
    logic signed [slew_pkg::DATA_W-1:0] r_in_target;
    logic                           r_out_valid;
    logic [slew_pkg::CHAN_W-1:0]    r_out_chan;
    logic signed [slew_pkg::DATA_W-1:0] r_out_value;
    logic                           n_in_valid;
    logic                           n_out_valid;
    logic                           accept;
    logic                           move;

    // datapath
    slew_pkg::t_chan_state          rd;
    slew_pkg::t_store_wr            wr;
    logic                           in_use;
    logic signed [slew_pkg::DATA_W-1:0] step_value;
    logic signed [slew_pkg::DATA_W-1:0] result;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign clr_loaded  = cfg_wr && (i_cfg_index == slew_pkg::CFG_CHANNEL_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_en    <= 1'b0;
            r_rise_coef  <= '0;
            r_fall_coef  <= '0;
            r_chan_count <= slew_pkg::CHAN_COUNT_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                slew_pkg::CFG_SLEW_ENABLE:   r_slew_en    <= i_cfg_data[0];
                slew_pkg::CFG_RISE_COEF:     r_rise_coef  <= i_cfg_data[slew_pkg::COEF_W-1:0];
                slew_pkg::CFG_FALL_COEF:     r_fall_coef  <= i_cfg_data[slew_pkg::COEF_W-1:0];
                slew_pkg::CFG_CHANNEL_COUNT: r_chan_count <= i_cfg_data[slew_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign move       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !move;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (move) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_chan   <= i_chan_index;
            r_in_target <= i_target_value;
        end
        if (move) begin
            r_out_chan  <= r_in_chan;
            r_out_value <= result;
        end
    end

    // channel state and step
    slew_store #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (clr_loaded),
        .i_rd_idx (r_in_chan),
        .o_rd     (rd),
        .i_wr     (wr)
    );

    slew_step u_step (
        .i_value     (rd.value),
        .i_target    (r_in_target),
        .i_rise_coef (r_rise_coef),
        .i_fall_coef (r_fall_coef),
        .o_result    (step_value)
    );

    assign in_use = ({1'b0, r_in_chan} < r_chan_count) && ({1'b0, r_in_chan} < SLOT_LIMIT);
    assign result = (in_use && rd.loaded && r_slew_en) ? step_value : r_in_target;

    assign wr.en    = move && in_use;
    assign wr.idx   = r_in_chan;
    assign wr.value = result;

    assign o_out_valid = r_out_valid;
    assign o_out_chan  = r_out_chan;
    assign o_out_value = r_out_value;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> (r_out_valid && (r_out_chan == $past(r_in_chan))))
        else $error("result register not filled by a moving item");

    a_bypass_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !in_use) |=> (r_out_value == $past(r_in_target)))
        else $error("unused channel did not pass its target");

endmodule
